### hdl/stt_pkg.sv
// Shared types and constants of the sparse triplet transpose block.
// No dependencies; every other file of the block imports this package.
package stt_pkg;

    // Default sizes of the term chain and of the column range
    localparam int MAX_TERMS_DEF = 32;
    localparam int MAX_DIM_DEF   = 32;

    // Field widths
    localparam int IDX_W = 5;
    localparam int DIM_W = 6;
    localparam int VAL_W = 32;

    // Reset value of both dimension registers
    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    // Configuration register indexes (APB word address bit 2)
    localparam logic REG_SOURCE_ROWS = 1'b0;
    localparam logic REG_SOURCE_COLS = 1'b1;

    // One stored source term
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_term;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the broadcast term in column order
        logic shl;  // move every term one cell towards the head
    } t_cell_ctl;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_HEADER,
        ST_TERMS
    } t_state;

endpackage

### hdl/stt_if.sv
// Handshake channels of the sparse triplet transpose block: input terms, results.
// Depends on stt_pkg for field widths.
interface stt_term_if;
    import stt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        term_row;
    logic [IDX_W-1:0]        term_col;
    logic signed [VAL_W-1:0] term_value;
    logic                    term_present;
    logic                    is_final;

    modport source (output valid, term_row, term_col, term_value, term_present, is_final,
                    input ready);
    modport sink   (input valid, term_row, term_col, term_value, term_present, is_final,
                    output ready);
endinterface

interface stt_result_if;
    import stt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    is_header;
    logic                    is_last_result;
    logic                    error_flag;

    modport source (output valid, out_row, out_col, out_value, is_header, is_last_result,
                    error_flag, input ready);
    modport sink   (input valid, out_row, out_col, out_value, is_header, is_last_result,
                    error_flag, output ready);
endinterface

### hdl/stt_cell.sv
// One cell of the term chain: holds one term, kept in column order with its neighbours.
// Depends on stt_pkg for t_term and t_cell_ctl.
module stt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stt_pkg::t_cell_ctl i_ctl,
    input  stt_pkg::t_term    i_new,
    input  stt_pkg::t_term    i_prev_term,
    input  logic              i_prev_valid,
    input  logic              i_prev_keep,
    input  stt_pkg::t_term    i_next_term,
    input  logic              i_next_valid,
    output stt_pkg::t_term    o_term,
    output logic              o_valid,
    output logic              o_keep
);
    import stt_pkg::*;

    t_term r_term, n_term;
    logic  r_valid, n_valid;

    // A term keeps its place when its column is not above the new one (stable order)
    assign o_keep  = r_valid && (r_term.col <= i_new.col);
    assign o_term  = r_term;
    assign o_valid = r_valid;

    // Choose between hold, take the new term, take the left neighbour, take the right one
    always_comb begin
        n_term  = r_term;
        n_valid = r_valid;
        priority if (i_ctl.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_term  = i_new;
                    n_valid = 1'b1;
                end else begin
                    n_term  = i_prev_term;
                    n_valid = i_prev_valid;
                end
            end
        end else if (i_ctl.shl) begin
            n_term  = i_next_term;
            n_valid = i_next_valid;
        end else begin
            n_term  = r_term;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

endmodule

### hdl/stt_cfg.sv
// APB register file of the sparse triplet transpose block: source rows and columns.
// Depends on stt_pkg for widths, reset values and register indexes.
module stt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [stt_pkg::DIM_W-1:0] o_source_rows,
    output logic [stt_pkg::DIM_W-1:0] o_source_cols
);
    import stt_pkg::*;

    logic [DIM_W-1:0] r_rows, r_cols;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_SOURCE_ROWS) begin
                r_rows <= pwdata[DIM_W-1:0];
            end else begin
                r_cols <= pwdata[DIM_W-1:0];
            end
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_SOURCE_COLS) ? {{(32-DIM_W){1'b0}}, r_cols}
                                                  : {{(32-DIM_W){1'b0}}, r_rows};

    assign o_source_rows = r_rows;
    assign o_source_cols = r_cols;

endmodule

### hdl/sparse_triplet_transpose.sv
// Sparse matrix transpose over (row, column, value) triplets.
// Channels: i_term takes one item per transfer (valid/ready); an item with
// term_present set carries one source term. o_result gives the results.
// Terms load at one per cycle into a chain of cells that keeps them sorted by
// column, equal columns in arrival order. The transfer of the item with
// is_final set ends the matrix: i_term.ready drops, and from the next cycle
// o_result shows a header (source_cols, source_rows, term count), then one
// result per stored term with row and column swapped, one per cycle while the
// receiver takes them. The chain moves one cell on each stored term and on
// each result taken. A term outside the configured dimensions, with a column
// at or above MAX_DIM, or beyond MAX_TERMS, is dropped and sets error_flag on
// every result of that matrix. A stalled receiver holds the current result
// and the chain. After the last result the block takes terms again with an
// empty chain. Reset empties the chain and sets both dimension registers to
// 32; no clearing pass is needed.
// Depends on stt_pkg, stt_if, stt_cell and stt_cfg.
module sparse_triplet_transpose #(
    parameter int MAX_TERMS = stt_pkg::MAX_TERMS_DEF,
    parameter int MAX_DIM   = stt_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stt_term_if.sink      i_term,
    stt_result_if.source  o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import stt_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dropped, n_dropped;

    logic [DIM_W-1:0] w_rows, w_cols;
    logic             w_in_xfer, w_out_xfer;
    logic             w_bad, w_full, w_store, w_drop;
    logic             w_in_ready, w_out_valid, w_last;
    t_cell_ctl        w_ctl;
    t_term            w_new;

    t_term            w_term  [MAX_TERMS];
    logic             w_valid [MAX_TERMS];
    logic             w_keep  [MAX_TERMS];
    logic [MAX_TERMS-1:0] w_valid_vec;

    // Configuration registers
    stt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_source_rows (w_rows),
        .o_source_cols (w_cols)
    );

    assign w_in_xfer  = i_term.valid && i_term.ready;
    assign w_out_xfer = o_result.valid && o_result.ready;

    // Check the incoming term against the dimensions and the free space
    assign w_bad   = ({1'b0, i_term.term_row} >= w_rows) ||
                     ({1'b0, i_term.term_col} >= w_cols) ||
                     (32'(i_term.term_col) >= 32'(MAX_DIM));
    assign w_full  = (r_count == CNT_FULL);
    assign w_store = w_in_xfer && i_term.term_present && !w_bad && !w_full;
    assign w_drop  = w_in_xfer && i_term.term_present && (w_bad || w_full);

    assign w_new.row   = i_term.term_row;
    assign w_new.col   = i_term.term_col;
    assign w_new.value = i_term.term_value;

    // Chain of cells, head at index zero
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        t_term w_prev_term, w_next_term;
        logic  w_prev_valid, w_prev_keep, w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_term  = w_new;
            assign w_prev_valid = 1'b0;
            assign w_prev_keep  = 1'b1;
        end else begin : g_body
            assign w_prev_term  = w_term[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == MAX_TERMS - 1) begin : g_tail
            assign w_next_term  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_term  = w_term[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        stt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_prev_term  (w_prev_term),
            .i_prev_valid (w_prev_valid),
            .i_prev_keep  (w_prev_keep),
            .i_next_term  (w_next_term),
            .i_next_valid (w_next_valid),
            .o_term       (w_term[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );

        assign w_valid_vec[g] = w_valid[g];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer && i_term.is_final) n_state = ST_HEADER;
            end
            ST_HEADER: begin
                if (w_out_xfer) n_state = (r_count == '0) ? ST_LOAD : ST_TERMS;
            end
            ST_TERMS: begin
                if (w_out_xfer && r_count == CNT_ONE) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_out_valid = 1'b0;
        w_last      = 1'b0;
        w_ctl       = '0;
        unique case (r_state)
            ST_LOAD: begin
                w_in_ready = 1'b1;
                w_ctl.ins  = w_store;
            end
            ST_HEADER: begin
                w_out_valid = 1'b1;
                w_last      = (r_count == '0);
            end
            ST_TERMS: begin
                w_out_valid = 1'b1;
                w_last      = (r_count == CNT_ONE);
                w_ctl.shl   = w_out_xfer;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // Term count and error mark
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_store) n_count = r_count + CNT_ONE;
        if (w_ctl.shl) n_count = r_count - CNT_ONE;
        if (w_drop) n_dropped = 1'b1;
        if (w_out_xfer && w_last) n_dropped = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Drive the channels: header from the registers, terms from the head cell
    assign i_term.ready            = w_in_ready;
    assign o_result.valid          = w_out_valid;
    assign o_result.is_header      = (r_state == ST_HEADER);
    assign o_result.is_last_result = w_last;
    assign o_result.error_flag     = r_dropped;
    assign o_result.out_row   = (r_state == ST_HEADER) ? w_cols
                                                       : {1'b0, w_term[0].col};
    assign o_result.out_col   = (r_state == ST_HEADER) ? w_rows
                                                       : {1'b0, w_term[0].row};
    assign o_result.out_value = (r_state == ST_HEADER) ? VAL_W'(r_count)
                                                       : w_term[0].value;

    // The chain holds exactly as many terms as the count says
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("chain occupancy differs from term count");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("term count beyond chain length");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_term.ready && o_result.valid))
        else $error("loading and emitting at once");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && w_last) |=> (r_count == '0) && !r_dropped && (r_state == ST_LOAD))
        else $error("run state not cleared after last result");

    a_final_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_term.is_final) |=> (r_state == ST_HEADER))
        else $error("final item did not start the header");

endmodule
